// ===== hw/rtl/knapsack_01_dp_solver_macros.svh =====
// Assertion helpers shared by the solver's modules.
// Each expects clk and rst_n in the scope where it is used.
`ifndef KNAPSACK_01_DP_SOLVER_MACROS_SVH
`define KNAPSACK_01_DP_SOLVER_MACROS_SVH

// Same-cycle implication, held off during reset
`define KDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define KDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kds_pkg.sv =====
package kds_pkg;

  // Field widths
  localparam int W_W         = 12;
  localparam int V_W         = 12;
  localparam int CAP_W       = 10;
  localparam int BEST_W      = 17;
  localparam int IDX_W       = 6;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // Input commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  // Commands from the sequencer to the table core
  typedef struct packed {
    logic issue;    // compute one table entry
    logic fit;      // item weight fits the entry's capacity
    logic first;    // first item: previous row reads as zero
    logic best_rd;  // read the best row at the capacity address
    logic take_rd;  // read one take bit
  } kds_dp_cmd_t;

endpackage

// ===== hw/rtl/kds_item_store.sv =====
module kds_item_store #(
  parameter int MAX_ITEMS = 32,
  localparam int IA_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  localparam int NW   = $clog2(MAX_ITEMS + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic                     clear,
  input  logic [kds_pkg::W_W-1:0]  wr_weight,
  input  logic [kds_pkg::V_W-1:0]  wr_value,
  input  logic                     rd_en,
  input  logic [IA_W-1:0]          rd_addr,
  output logic [kds_pkg::W_W-1:0]  rd_weight,
  output logic [kds_pkg::V_W-1:0]  rd_value,
  output logic [NW-1:0]            count
);
  import kds_pkg::*;

  logic [W_W+V_W-1:0] mem [MAX_ITEMS];
  logic [W_W+V_W-1:0] rd_q_r;
  logic [NW-1:0]      count_r;
  logic               full;

  assign full = (count_r == NW'(MAX_ITEMS));

  // Track the fill level; drop loads once full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (clear) begin
      count_r <= '0;
    end else if (load && !full) begin
      count_r <= count_r + NW'(1);
    end
  end

  // Write at the fill level, read registered
  always_ff @(posedge clk) begin
    if (load && !full) begin
      mem[count_r[IA_W-1:0]] <= {wr_value, wr_weight};
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_weight = rd_q_r[W_W-1:0];
  assign rd_value  = rd_q_r[W_W+V_W-1:W_W];
  assign count     = count_r;

endmodule

// ===== hw/rtl/kds_dp_core.sv =====
module kds_dp_core #(
  parameter int MAX_ITEMS    = 32,
  parameter int MAX_CAPACITY = 1023,
  localparam int IA_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
  localparam int NW    = $clog2(MAX_ITEMS + 1),
  localparam int CW    = $clog2(MAX_CAPACITY + 1),
  localparam int ROW_W = kds_pkg::V_W + NW
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  kds_pkg::kds_dp_cmd_t     cmd,
  input  logic [CW-1:0]            rd_c,
  input  logic [CW-1:0]            rd_cw,
  input  logic [IA_W-1:0]          item_sel,
  input  logic [kds_pkg::V_W-1:0]  item_value,
  output logic [ROW_W-1:0]         best_q,
  output logic                     take_q
);
  import kds_pkg::*;

  localparam int ROW_DEPTH = MAX_CAPACITY + 1;
  localparam int TK_DEPTH  = MAX_ITEMS * (2 ** CW);

  logic [ROW_W-1:0] row_mem [ROW_DEPTH];
  logic             tk_mem  [TK_DEPTH];

  logic [ROW_W-1:0] rd_a_q_r;
  logic [ROW_W-1:0] rd_b_q_r;
  logic             take_q_r;

  logic             p_vld_r;
  logic             p_fit_r;
  logic             p_first_r;
  logic [CW-1:0]    p_c_r;
  logic [IA_W-1:0]  p_i_r;
  logic [V_W-1:0]   p_v_r;

  logic [ROW_W-1:0] prev;
  logic [ROW_W-1:0] with_v;
  logic             take;
  logic [ROW_W-1:0] upd;

  // Advance the entry pipeline alongside the row reads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      p_fit_r   <= cmd.fit;
      p_first_r <= cmd.first;
      p_c_r     <= rd_c;
      p_i_r     <= item_sel;
      p_v_r     <= item_value;
    end
  end

  // Compare leaving against taking; the first item sees a zero row
  always_comb begin
    prev   = p_first_r ? '0 : rd_a_q_r;
    with_v = (p_first_r ? '0 : rd_b_q_r) + ROW_W'(p_v_r);
    take   = p_fit_r && (with_v > prev);
    upd    = take ? with_v : prev;
  end

  // Best row: two registered reads, one write back
  always_ff @(posedge clk) begin
    if (cmd.issue || cmd.best_rd) begin
      rd_a_q_r <= row_mem[rd_c];
    end
    if (cmd.issue) begin
      rd_b_q_r <= row_mem[rd_cw];
    end
    if (p_vld_r) begin
      row_mem[p_c_r] <= upd;
    end
  end

  // Take bits: written per entry, read back during the trace
  always_ff @(posedge clk) begin
    if (p_vld_r) begin
      tk_mem[{p_i_r, p_c_r}] <= take;
    end
    if (cmd.take_rd) begin
      take_q_r <= tk_mem[{item_sel, rd_c}];
    end
  end

  assign best_q = rd_a_q_r;
  assign take_q = take_q_r;

`include "knapsack_01_dp_solver_macros.svh"

  `KDS_ASSERT_IMP(a_no_read_over_write, p_vld_r, !cmd.take_rd && !cmd.best_rd, "read while a table write is pending")
  `KDS_ASSERT_IMP(a_row_descends, cmd.issue && p_vld_r, (CW+1)'(rd_c) + (CW+1)'(1) == (CW+1)'(p_c_r), "row entries not strictly descending")
  `KDS_ASSERT_IMP(a_offset_below, cmd.issue, rd_cw <= rd_c, "offset read above the entry")

endmodule

// ===== hw/rtl/knapsack_01_dp_solver.sv =====
// Channel | Dir | Handshake             | Payload
// in_     | in  | in_tvalid/in_tready   | tuser cmd; tdata weight, value
// out_    | out | out_tvalid/out_tready | tdata best_value, item_index; tlast
// cfg_    | in  | cfg_valid/cfg_ready   | cfg_data capacity
//
// A load stores one item. A solve with n items and capacity C fills the table row
// by row (one entry a cycle through the best-row memory, from C down to zero, after
// a fetch of the row's item), traces the take bits back from the last item to the
// first, then scans the indices upward to the highest chosen item.
// No clearing pass follows reset: the first item's row reads its previous row as zero.
// Input is taken only between solves; the output register holds a result under stall.
module knapsack_01_dp_solver #(
  parameter int MAX_ITEMS    = 32,
  parameter int MAX_CAPACITY = 1023
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [kds_pkg::IN_TDATA_W-1:0]  in_tdata,   // [11:0] item_weight, [23:12] item_value
  input  logic                            in_tuser,   // [0] cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [kds_pkg::OUT_TDATA_W-1:0] out_tdata,  // [16:0] best_value, [22:17] item_index
  output logic                            out_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kds_pkg::CAP_W-1:0]       cfg_data
);
  import kds_pkg::*;

  localparam int IA_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int NW    = $clog2(MAX_ITEMS + 1);
  localparam int CW    = $clog2(MAX_CAPACITY + 1);
  localparam int CWX   = (CW > W_W) ? CW : W_W;
  localparam int CAPX  = (CW > CAP_W) ? CW : CAP_W;
  localparam int ROW_W = V_W + NW;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_ROW, S_DRAIN, S_BEST, S_TR_RD, S_TR_CHK, S_EMIT
  } state_t;

  state_t           state_r;
  logic [CAP_W-1:0] capacity_r;
  logic [CW-1:0]    cap_r;
  logic [CW-1:0]    c_r;
  logic [IA_W-1:0]  i_r;
  logic [NW-1:0]    n_r;
  logic [MAX_ITEMS-1:0] flags_r;
  logic             found_r;
  logic [IA_W-1:0]  last_idx_r;
  logic [IA_W-1:0]  j_r;
  logic [ROW_W-1:0] best_r;
  logic             out_tvalid_r;
  logic [BEST_W-1:0] out_best_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_last_r;

  logic             in_acc;
  logic             ld;
  logic             solve_acc;
  logic             emit_go;
  logic [NW-1:0]    count;
  logic [W_W-1:0]   st_weight;
  logic [V_W-1:0]   st_value;
  logic             st_rd_en;
  logic [CW-1:0]    cap_sat;
  logic             fit;
  logic [CW-1:0]    c_less_w;
  logic             last_item;
  logic             out_free;
  logic [ROW_W-1:0] best_q;
  logic             take_q;
  kds_dp_cmd_t      dp_cmd;
  logic [CW-1:0]    dp_c;
  logic [CW-1:0]    dp_cw;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign ld        = in_acc && (in_tuser == CMD_LOAD);
  assign solve_acc = in_acc && (in_tuser == CMD_SOLVE);
  assign out_free  = !out_tvalid_r || out_tready;
  assign emit_go   = (state_r == S_EMIT) && out_free && (!found_r || flags_r[j_r]);

  // Saturate the capacity register to MAX_CAPACITY, the last table address
  always_comb begin
    if (CAPX'(capacity_r) > CAPX'(MAX_CAPACITY)) begin
      cap_sat = CW'(MAX_CAPACITY);
    end else begin
      cap_sat = CW'(capacity_r);
    end
  end

  // Weight against the current capacity
  always_comb begin
    fit       = CWX'(st_weight) <= CWX'(c_r);
    c_less_w  = CW'(CWX'(c_r) - CWX'(st_weight));
    last_item = (NW'(i_r) + NW'(1)) == n_r;
  end

  // Drive the table core
  always_comb begin
    dp_cmd         = '0;
    dp_cmd.issue   = (state_r == S_ROW);
    dp_cmd.fit     = fit;
    dp_cmd.first   = (i_r == '0);
    dp_cmd.best_rd = (state_r == S_BEST);
    dp_cmd.take_rd = (state_r == S_TR_RD);
    dp_c           = (state_r == S_BEST) ? cap_r : c_r;
    dp_cw          = fit ? c_less_w : c_r;
  end

  assign st_rd_en = (state_r == S_FETCH) || (state_r == S_TR_RD);

  kds_item_store #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ld),
    .clear     (solve_acc),
    .wr_weight (in_tdata[W_W-1:0]),
    .wr_value  (in_tdata[W_W+V_W-1:W_W]),
    .rd_en     (st_rd_en),
    .rd_addr   (i_r),
    .rd_weight (st_weight),
    .rd_value  (st_value),
    .count     (count)
  );

  kds_dp_core #(
    .MAX_ITEMS    (MAX_ITEMS),
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (dp_cmd),
    .rd_c       (dp_c),
    .rd_cw      (dp_cw),
    .item_sel   (i_r),
    .item_value (st_value),
    .best_q     (best_q),
    .take_q     (take_q)
  );

  // Sequence the solve: fill rows, trace back, emit in ascending order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      capacity_r   <= '0;
      out_tvalid_r <= 1'b0;
      found_r      <= 1'b0;
      flags_r      <= '0;
    end else begin
      if (cfg_valid) begin
        capacity_r <= cfg_data;
      end
      // Raise valid on a new result, drop it once taken
      if (emit_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (solve_acc) begin
            n_r     <= count;
            cap_r   <= cap_sat;
            i_r     <= '0;
            j_r     <= '0;
            flags_r <= '0;
            found_r <= 1'b0;
            best_r  <= '0;
            state_r <= (count == '0) ? S_EMIT : S_FETCH;
          end
        end
        S_FETCH: begin
          c_r     <= cap_r;
          state_r <= S_ROW;
        end
        S_ROW: begin
          if (c_r == '0) begin
            if (last_item) begin
              state_r <= S_DRAIN;
            end else begin
              i_r     <= i_r + IA_W'(1);
              state_r <= S_FETCH;
            end
          end else begin
            c_r <= c_r - CW'(1);
          end
        end
        S_DRAIN: begin
          state_r <= S_BEST;
        end
        S_BEST: begin
          c_r     <= cap_r;
          state_r <= S_TR_RD;
        end
        S_TR_RD: begin
          best_r  <= best_q;
          state_r <= S_TR_CHK;
        end
        S_TR_CHK: begin
          if (take_q) begin
            flags_r[i_r] <= 1'b1;
            c_r          <= c_less_w;
            if (!found_r) begin
              found_r    <= 1'b1;
              last_idx_r <= i_r;
            end
          end
          if (i_r == '0) begin
            state_r <= S_EMIT;
          end else begin
            i_r     <= i_r - IA_W'(1);
            state_r <= S_TR_RD;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (!found_r) begin
              out_best_r   <= BEST_W'(best_r);
              out_idx_r    <= '0;
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end else if (flags_r[j_r]) begin
              out_best_r   <= BEST_W'(best_r);
              out_idx_r    <= IDX_W'(NW'(j_r) + NW'(1));
              out_last_r   <= (j_r == last_idx_r);
              j_r          <= j_r + IA_W'(1);
              if (j_r == last_idx_r) begin
                state_r <= S_IDLE;
              end
            end else begin
              j_r <= j_r + IA_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_idx_r, out_best_r};
  assign out_tlast  = out_last_r;

`include "knapsack_01_dp_solver_macros.svh"

  `KDS_ASSERT_NXT(a_solve_leaves_idle, solve_acc, state_r != S_IDLE, "solve did not start")
  `KDS_ASSERT_IMP(a_row_in_range, state_r == S_ROW, NW'(i_r) < n_r, "row beyond the item count")
  `KDS_ASSERT_IMP(a_take_fits, (state_r == S_TR_CHK) && take_q, CWX'(st_weight) <= CWX'(c_r), "traced item does not fit")

endmodule
